>>> sv/lockstep_input_sync_server_top_defines.svh
// Assertion macros used by the lockstep input sync server datapath.
`ifndef LOCKSTEP_INPUT_SYNC_SERVER_TOP_DEFINES_SVH
`define LOCKSTEP_INPUT_SYNC_SERVER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LISS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define LISS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define LISS_ASSERT(label, prop, msg)
`define LISS_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

>>> sv/liss_pkg.sv
// Package with types, constants and packet functions of the lockstep input sync server.
`default_nettype none
package liss_pkg;

    localparam int MAX_SLOTS     = 5;
    localparam int REQUEST_DEPTH = 8;
    localparam int MAX_RESULTS   = 5;
    localparam int REQ_IW = (REQUEST_DEPTH > 1) ? $clog2(REQUEST_DEPTH) : 1;
    localparam int REQ_CW = $clog2(REQUEST_DEPTH + 1);

    localparam logic [7:0] ID_IDENT   = 8'h55;
    localparam logic [7:0] ID_ACK     = 8'h96;
    localparam logic [7:0] ID_STATUS  = 8'hC2;
    localparam logic [7:0] ID_DIGEST  = 8'h3B;
    localparam logic [7:0] LEN_IDENT  = 8'd8;
    localparam logic [7:0] LEN_STATUS = 8'd11;
    localparam logic [3:0] OUT_LEN_ACK = 4'd3;
    localparam logic [3:0] OUT_LEN_DIG = 4'd11;

    typedef struct packed {
        logic [31:0] src_host;
        logic [15:0] src_port;
        logic [7:0]  pkt_len;
        logic [63:0] pkt_head;
        logic [23:0] pkt_tail;
    } t_in_item;

    typedef struct packed {
        logic [31:0] dest_host;
        logic [15:0] dest_port;
        logic [3:0]  out_len;
        logic [63:0] out_head;
        logic [23:0] out_tail;
        logic        last;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_SEARCH, S_ALLOC, S_ACK, S_STORE,
        S_PREV, S_CHECK, S_DIG, S_ADV, S_FLUSH
    } t_state;

    typedef enum logic [1:0] {
        SRC_ACK, SRC_PREV, SRC_DIG
    } t_emit_src;

    typedef struct packed {
        logic      load;
        logic      decode;
        logic      search;
        logic      alloc;
        logic      store;
        logic      check;
        logic      dig_step;
        logic      advance;
        logic      flush;
        logic      emit;
        t_emit_src src;
    } t_cmd;

    typedef struct packed {
        logic is_ident;
        logic is_cur;
        logic is_prev;
        logic search_done;
        logic all_ready;
        logic dig_dup;
        logic dig_last;
        logic out_free;
        logic pend_valid;
    } t_status;

    function automatic logic [7:0] rotl8(input logic [7:0] x, input logic [2:0] r);
        logic [15:0] t;
        t = {x, x} << r;
        return t[15:8];
    endfunction

    // The rotate-and-xor checksum is linear, so each byte enters rotated by its distance.
    function automatic logic [7:0] csum(input logic [87:0] b, input int n);
        logic [7:0] c;
        c = 8'h00;
        for (int i = 0; i < 11; i++) begin
            if (i < n) begin
                c = c ^ rotl8(b[87-8*i -: 8], 3'(n - i));
            end
        end
        return c;
    endfunction

    function automatic logic [87:0] digest_bytes(input logic [31:0] frame,
                                                 input logic [39:0] vals,
                                                 input logic [2:0]  cnt);
        logic [39:0] mv;
        logic [87:0] b;
        mv = 40'd0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            if (3'(i) < cnt) begin
                mv[39-8*i -: 8] = vals[39-8*i -: 8];
            end
        end
        b = {ID_DIGEST, frame, mv, 8'h00};
        b[7:0] = csum(b, 10);
        return b;
    endfunction

endpackage
`default_nettype wire

>>> sv/lockstep_input_sync_server_top.sv
// Top level of the lockstep input sync server: controller and datapath.
//
// Usage: one received datagram enters per item on the input channel
// (i_in_valid / o_in_ready). The replies it causes leave on the output
// channel (o_out_valid / i_out_ready), zero to five items, the final one
// marked with last. The user must write the player count register through
// i_cfg_we / i_cfg_data only while the block is idle; the block itself does
// not enforce this. A status store or a previous digest passes through its
// own state, and an identification scans the request table one entry a
// cycle, then allocates and acknowledges. When all active slots are
// ready, a digest goes to each active slot address in turn and the
// frame advances. Each reply is held back one
// place so that last can be set, so it reaches the output register one emit
// step later than it is built. A new item is taken only after all replies
// of the previous one are in the output register.
// Reset clears the frame counter, all slots and the request count and
// sets the player count to 2. When the receiver stalls, the sequencer
// waits at its next emit step and no reply is lost.
`default_nettype none
module lockstep_input_sync_server_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire liss_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output liss_pkg::t_out_item      o_out_data,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_data
);

    liss_pkg::t_cmd    cmd;
    liss_pkg::t_status st;

    liss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    liss_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_st        (st)
    );

endmodule
`default_nettype wire

>>> sv/liss_ctrl.sv
// Controller state machine that sequences the handling of one received item.
`default_nettype none
module liss_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire liss_pkg::t_status i_st,
    output liss_pkg::t_cmd       o_cmd
);

    liss_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= liss_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.src  = liss_pkg::SRC_ACK;
        unique case (r_state)
            liss_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = liss_pkg::S_DECODE;
                end
            end
            liss_pkg::S_DECODE: begin
                o_cmd.decode = 1'b1;
                if (i_st.is_ident) begin
                    n_state = liss_pkg::S_SEARCH;
                end else if (i_st.is_cur) begin
                    n_state = liss_pkg::S_STORE;
                end else if (i_st.is_prev) begin
                    n_state = liss_pkg::S_PREV;
                end else begin
                    n_state = liss_pkg::S_CHECK;
                end
            end
            liss_pkg::S_SEARCH: begin
                if (i_st.search_done) begin
                    n_state = liss_pkg::S_ALLOC;
                end else begin
                    o_cmd.search = 1'b1;
                end
            end
            liss_pkg::S_ALLOC: begin
                o_cmd.alloc = 1'b1;
                n_state     = liss_pkg::S_ACK;
            end
            liss_pkg::S_ACK: begin
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = liss_pkg::SRC_ACK;
                    n_state    = liss_pkg::S_CHECK;
                end
            end
            liss_pkg::S_STORE: begin
                o_cmd.store = 1'b1;
                n_state     = liss_pkg::S_CHECK;
            end
            liss_pkg::S_PREV: begin
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = liss_pkg::SRC_PREV;
                    n_state    = liss_pkg::S_CHECK;
                end
            end
            liss_pkg::S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state = i_st.all_ready ? liss_pkg::S_DIG : liss_pkg::S_FLUSH;
            end
            liss_pkg::S_DIG: begin
                if (i_st.out_free) begin
                    o_cmd.emit     = !i_st.dig_dup;
                    o_cmd.src      = liss_pkg::SRC_DIG;
                    o_cmd.dig_step = 1'b1;
                    if (i_st.dig_last) begin
                        n_state = liss_pkg::S_ADV;
                    end
                end
            end
            liss_pkg::S_ADV: begin
                o_cmd.advance = 1'b1;
                n_state       = liss_pkg::S_FLUSH;
            end
            liss_pkg::S_FLUSH: begin
                if (!i_st.pend_valid) begin
                    n_state = liss_pkg::S_IDLE;
                end else if (i_st.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = liss_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = liss_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> sv/liss_dp.sv
// Datapath with slot state, request table, packet builders and the output register.
`default_nettype none
`include "lockstep_input_sync_server_top_defines.svh"
module liss_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire liss_pkg::t_in_item  i_in_data,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_data,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output liss_pkg::t_out_item      o_out_data,
    input  wire liss_pkg::t_cmd      i_cmd,
    output liss_pkg::t_status        o_st
);

    liss_pkg::t_in_item  r_in;
    logic [2:0]          r_player_count;
    logic [31:0]         r_frame;
    logic [2:0]          r_ident;
    logic [47:0]         r_slot_addr [liss_pkg::MAX_SLOTS];
    logic                r_mapped    [liss_pkg::MAX_SLOTS];
    logic [7:0]          r_dev       [liss_pkg::MAX_SLOTS];
    logic                r_ready     [liss_pkg::MAX_SLOTS];
    logic [7:0]          r_cur       [liss_pkg::MAX_SLOTS];
    logic [7:0]          r_prev      [liss_pkg::MAX_SLOTS];
    logic [50:0]         r_req_tab   [liss_pkg::REQUEST_DEPTH];
    logic [liss_pkg::REQ_CW-1:0] r_req_cnt;
    logic [liss_pkg::REQ_CW-1:0] r_k;
    logic                r_found;
    logic [2:0]          r_alloc;
    logic [2:0]          r_slot;
    logic [2:0]          r_n;
    logic [87:0]         r_dig;
    liss_pkg::t_out_item r_pend;
    logic                r_pend_v;
    liss_pkg::t_out_item r_out;
    logic                r_out_v;

    logic [47:0] addr;
    logic [63:0] head;
    logic [2:0]  cnt;
    logic [2:0]  remain;
    logic [2:0]  alloc_new;
    logic [31:0] frame_in;
    logic        is_stat;
    logic        req_hit;
    logic        all_ready;
    logic        dig_dup;
    logic [39:0] cur_vals;
    logic [39:0] prev_vals;
    logic [39:0] stat_vals;
    logic [87:0] prev_b;
    logic [87:0] ack_b;
    liss_pkg::t_out_item pkt;
    liss_pkg::t_out_item pend_out;
    logic        can_emit;
    logic        push;

    assign addr     = {r_in.src_host, r_in.src_port};
    assign head     = r_in.pkt_head;
    assign frame_in = head[55:24];
    assign stat_vals = {head[23:0], r_in.pkt_tail[23:8]};

    always_comb begin
        if (r_player_count == 3'd0) begin
            cnt = 3'd1;
        end else if (r_player_count > 3'(liss_pkg::MAX_SLOTS)) begin
            cnt = 3'(liss_pkg::MAX_SLOTS);
        end else begin
            cnt = r_player_count;
        end
    end

    assign remain    = (cnt > r_ident) ? (cnt - r_ident) : 3'd0;
    assign alloc_new = (head[55:48] < {5'd0, remain}) ? head[50:48] : remain;
    assign is_stat   = (r_in.pkt_len == liss_pkg::LEN_STATUS) &&
                       (head[63:56] == liss_pkg::ID_STATUS);
    assign req_hit   = (r_req_tab[r_k[liss_pkg::REQ_IW-1:0]][50:3] == addr);

    always_comb begin
        all_ready = 1'b1;
        dig_dup   = 1'b0;
        for (int i = 0; i < liss_pkg::MAX_SLOTS; i++) begin
            cur_vals[39-8*i -: 8]  = r_cur[i];
            prev_vals[39-8*i -: 8] = r_prev[i];
            if (3'(i) < cnt && !r_ready[i]) begin
                all_ready = 1'b0;
            end
            if (3'(i) < r_slot && r_slot_addr[i] == r_slot_addr[r_slot]) begin
                dig_dup = 1'b1;
            end
        end
    end

    assign prev_b = liss_pkg::digest_bytes(r_frame - 32'd1, prev_vals, cnt);

    always_comb begin
        ack_b = {liss_pkg::ID_ACK, 5'd0, r_alloc, 72'd0};
        ack_b[71:64] = liss_pkg::csum(ack_b, 2);
    end

    always_comb begin
        pkt = '0;
        case (i_cmd.src)
            liss_pkg::SRC_ACK: begin
                {pkt.dest_host, pkt.dest_port} = addr;
                pkt.out_len = liss_pkg::OUT_LEN_ACK;
                {pkt.out_head, pkt.out_tail} = ack_b;
            end
            liss_pkg::SRC_PREV: begin
                {pkt.dest_host, pkt.dest_port} = addr;
                pkt.out_len = liss_pkg::OUT_LEN_DIG;
                {pkt.out_head, pkt.out_tail} = prev_b;
            end
            liss_pkg::SRC_DIG: begin
                {pkt.dest_host, pkt.dest_port} = r_slot_addr[r_slot];
                pkt.out_len = liss_pkg::OUT_LEN_DIG;
                {pkt.out_head, pkt.out_tail} = r_dig;
            end
            default: begin
                pkt = '0;
            end
        endcase
    end

    always_comb begin
        pend_out      = r_pend;
        pend_out.last = i_cmd.flush;
    end

    assign can_emit = i_cmd.emit && (r_n < 3'(liss_pkg::MAX_RESULTS));
    assign push     = r_pend_v && (can_emit || i_cmd.flush);

    always_comb begin
        o_st             = '0;
        o_st.is_ident    = (r_in.pkt_len == liss_pkg::LEN_IDENT) &&
                           (head[63:56] == liss_pkg::ID_IDENT) &&
                           (head[7:0] == liss_pkg::csum({head, 24'd0}, 7));
        o_st.is_cur      = is_stat && (frame_in == r_frame);
        o_st.is_prev     = is_stat && (frame_in != r_frame) &&
                           (r_frame == frame_in + 32'd1);
        o_st.search_done = r_found || (r_k >= r_req_cnt);
        o_st.all_ready   = all_ready;
        o_st.dig_dup     = dig_dup;
        o_st.dig_last    = (r_slot == cnt - 3'd1);
        o_st.out_free    = !r_out_v || i_out_ready;
        o_st.pend_valid  = r_pend_v;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_data;
        end
        if (i_cmd.check) begin
            r_dig <= liss_pkg::digest_bytes(r_frame, cur_vals, cnt);
        end
        if (i_cmd.alloc && !r_found && r_req_cnt < liss_pkg::REQ_CW'(liss_pkg::REQUEST_DEPTH)) begin
            r_req_tab[r_req_cnt[liss_pkg::REQ_IW-1:0]] <= {addr, r_alloc};
        end
        if (can_emit) begin
            r_pend <= pkt;
        end
        if (push) begin
            r_out <= pend_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_player_count <= 3'd2;
            r_frame        <= 32'd0;
            r_ident        <= 3'd0;
            r_req_cnt      <= '0;
            r_k            <= '0;
            r_found        <= 1'b0;
            r_alloc        <= 3'd0;
            r_slot         <= 3'd0;
            r_n            <= 3'd0;
            r_pend_v       <= 1'b0;
            r_out_v        <= 1'b0;
            for (int i = 0; i < liss_pkg::MAX_SLOTS; i++) begin
                r_slot_addr[i] <= 48'd0;
                r_mapped[i]    <= 1'b0;
                r_dev[i]       <= 8'd0;
                r_ready[i]     <= 1'b0;
                r_cur[i]       <= 8'd0;
                r_prev[i]      <= 8'd0;
            end
        end else begin
            if (i_cfg_we) begin
                r_player_count <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_n <= 3'd0;
            end
            if (i_cmd.decode) begin
                r_k     <= '0;
                r_found <= 1'b0;
                r_alloc <= alloc_new;
            end
            if (i_cmd.search) begin
                if (req_hit) begin
                    r_found <= 1'b1;
                    r_alloc <= r_req_tab[r_k[liss_pkg::REQ_IW-1:0]][2:0];
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
            if (i_cmd.alloc && !r_found) begin
                for (int s = 0; s < liss_pkg::MAX_SLOTS; s++) begin
                    if (3'(s) >= r_ident && (3'(s) - r_ident) < r_alloc) begin
                        r_slot_addr[s] <= addr;
                        r_dev[s]       <= head[47-8*(s-int'(r_ident)) -: 8];
                        r_mapped[s]    <= 1'b1;
                        r_ready[s]     <= 1'b0;
                    end
                end
                if (r_req_cnt < liss_pkg::REQ_CW'(liss_pkg::REQUEST_DEPTH)) begin
                    r_req_cnt <= r_req_cnt + 1'b1;
                end
                r_ident <= r_ident + r_alloc;
            end
            if (i_cmd.store) begin
                for (int i = 0; i < liss_pkg::MAX_SLOTS; i++) begin
                    if (r_mapped[i] && r_slot_addr[i] == addr) begin
                        r_cur[i]   <= (r_dev[i] <= 8'd4) ?
                                      stat_vals[39-8*r_dev[i][2:0] -: 8] : 8'd0;
                        r_ready[i] <= 1'b1;
                    end
                end
            end
            if (i_cmd.check) begin
                r_slot <= 3'd0;
            end
            if (i_cmd.dig_step) begin
                r_slot <= r_slot + 3'd1;
            end
            if (i_cmd.advance) begin
                r_frame <= r_frame + 32'd1;
                for (int i = 0; i < liss_pkg::MAX_SLOTS; i++) begin
                    if (3'(i) < cnt) begin
                        r_prev[i]  <= r_cur[i];
                        r_cur[i]   <= 8'd0;
                        r_ready[i] <= 1'b0;
                    end
                end
            end
            if (can_emit) begin
                r_pend_v <= 1'b1;
                r_n      <= r_n + 3'd1;
            end else if (i_cmd.flush) begin
                r_pend_v <= 1'b0;
            end
            if (push) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    `LISS_ASSERT(a_ident_bound, r_ident <= 3'(liss_pkg::MAX_SLOTS), "identified slots exceed the slot count")
    `LISS_ASSERT(a_result_bound, r_n <= 3'(liss_pkg::MAX_RESULTS), "too many results for one item")
    `LISS_ASSERT(a_req_bound, r_req_cnt <= liss_pkg::REQ_CW'(liss_pkg::REQUEST_DEPTH), "request count overflow")
    `LISS_ASSERT(a_frame_step, i_cmd.advance |=> r_frame == $past(r_frame) + 32'd1, "frame did not advance")
    `LISS_ASSERT_ALWAYS(a_flush_pend, i_cmd.flush |-> r_pend_v, "flush without a pending item")

endmodule
`default_nettype wire
